/* rtl/nfca_anticollision_select_defines.svh */
// Assertion macros shared by the anticollision/select RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef NFCA_ANTICOLLISION_SELECT_DEFINES_SVH
`define NFCA_ANTICOLLISION_SELECT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NFCA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define NFCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nfca_pkg.sv */
// Types, codes and helpers for the ISO 14443-A anticollision/select block.
// No dependencies; used by nfca_anticollision_select.
package nfca_pkg;

    localparam int LEVEL_BITS  = 40;
    localparam int NUM_LEVELS  = 3;
    localparam int MAX_LEVELS  = 3;

    localparam logic [7:0] SEL_BASE    = 8'h91;
    localparam logic [7:0] CT_BYTE     = 8'h88;
    localparam logic [7:0] CASCADE_BIT = 8'h04;
    localparam logic [7:0] NVB_SELECT  = 8'h70;
    localparam logic [5:0] TX_SELECT   = 6'd56;
    localparam logic [5:0] TX_HDR_BITS = 6'd16;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_ANTICOLL = 2'd1,
        CMD_SAK      = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ANTICOLL = 2'd0,
        KIND_SELECT   = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_RX_FAIL  = 3'd1,
        ERR_CHECK    = 3'd2,
        ERR_NO_PROG  = 3'd3,
        ERR_LEVELS   = 3'd4,
        ERR_SEQUENCE = 3'd5
    } err_t;

    // result beat payload, last member lands in the lowest bits
    typedef struct packed {
        logic [2:0]  error_code;
        logic [7:0]  sak_out;
        logic [3:0]  uid_len;
        logic [15:0] uid_high;
        logic [63:0] uid_low;
        logic [5:0]  tx_bits;
        logic [39:0] frame_uid;
        logic [7:0]  nvb;
        logic [7:0]  sel_code;
    } res_t;

    // XOR of the four UID bytes must equal the BCC byte
    function automatic logic bcc_ok(input logic [LEVEL_BITS-1:0] lv);
        return (lv[7:0] ^ lv[15:8] ^ lv[23:16] ^ lv[31:24]) == lv[39:32];
    endfunction

endpackage

/* rtl/nfca_anticollision_select.sv */
// Top level: reader-side ISO 14443-A bit-oriented anticollision and cascade select.
// Depends on nfca_pkg and nfca_anticollision_select_defines.svh.
//
//  channel | dir | tdata                                         | tuser
//  s_      | in  | rx_bits, rx_data, rx_fail, sak_byte (56 bits) | cmd
//  m_      | out | frame fields, final UID, SAK, error (160 bits)| kind
//
// Every beat yields exactly one result beat. An accepted beat is held in the
// input register until the result side can take it, then one pass of merge/check
// logic writes the result register and the level/UID state. A new beat is
// taken every cycle while the result side keeps up.
// A stalled result holds in the output register; the input register then
// holds one more beat and s_tready drops. Reset (aresetn low, synchronous)
// empties both registers, clears the UID store, level 1, phase idle.
`include "nfca_anticollision_select_defines.svh"

module nfca_anticollision_select (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [5:0] rx_bits, [45:6] rx_data, [46] rx_fail, [54:47] sak_byte, [55] zero
    input  logic [55:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] sel_code, [15:8] nvb, [55:16] frame_uid, [61:56] tx_bits,
    // [125:62] uid_low, [141:126] uid_high, [145:142] uid_len,
    // [153:146] sak_out, [156:154] error_code, [159:157] zero
    output logic [159:0] m_tdata,
    // [1:0] kind
    output logic [1:0]   m_tuser
);

    localparam int LB = nfca_pkg::LEVEL_BITS;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ANTICOLL,
        PH_SELWAIT
    } phase_t;

    // input register
    logic          in_vld_reg, in_vld_next;
    logic [1:0]    in_cmd_reg, in_cmd_next;
    logic [5:0]    in_bits_reg, in_bits_next;
    logic [LB-1:0] in_data_reg, in_data_next;
    logic          in_fail_reg, in_fail_next;
    logic [7:0]    in_sak_reg, in_sak_next;

    // result register
    logic             out_vld_reg, out_vld_next;
    nfca_pkg::kind_t  out_kind_reg, out_kind_next;
    nfca_pkg::res_t   out_res_reg, out_res_next;

    // protocol state
    phase_t        phase_reg, phase_next;
    logic [1:0]    level_reg, level_next;
    logic [5:0]    known_reg, known_next;
    logic [LB-1:0] uid_reg [nfca_pkg::NUM_LEVELS];
    logic [LB-1:0] uid_next [nfca_pkg::NUM_LEVELS];

    logic adv, fire, take_in;

    assign adv      = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && adv;
    assign s_tready = !in_vld_reg || adv;
    assign take_in  = s_tvalid && s_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    // handshake bookkeeping
    always_comb begin
        in_vld_next  = in_vld_reg;
        in_cmd_next  = in_cmd_reg;
        in_bits_next = in_bits_reg;
        in_data_next = in_data_reg;
        in_fail_next = in_fail_reg;
        in_sak_next  = in_sak_reg;
        if (take_in) begin
            in_vld_next  = 1'b1;
            in_cmd_next  = s_tuser;
            in_bits_next = s_tdata[5:0];
            in_data_next = s_tdata[45:6];
            in_fail_next = s_tdata[46];
            in_sak_next  = s_tdata[54:47];
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    // current level's 40 UID bits
    logic [1:0]    lvl_idx;
    logic [LB-1:0] cur_bits;

    always_comb begin
        case (level_reg)
            2'd2:    lvl_idx = 2'd1;
            2'd3:    lvl_idx = 2'd2;
            default: lvl_idx = 2'd0;
        endcase
    end
    assign cur_bits = uid_reg[lvl_idx];

    // bit merge at the known-bit position; known never exceeds 40
    logic [5:0]    room, take, new_known;
    logic [LB-1:0] merge_mask, merged;

    assign room       = 6'(LB) - known_reg;
    assign take       = (in_bits_reg < room) ? in_bits_reg : room;
    assign new_known  = known_reg + take;
    assign merge_mask = ~({LB{1'b1}} << new_known) & ({LB{1'b1}} << known_reg);
    assign merged     = (cur_bits & ~merge_mask) | ((in_data_reg << known_reg) & merge_mask);

    // final UID assembly and checks, one per level count
    logic [LB-1:0] u0, u1, u2;
    logic          chk1, chk2, chk3;

    assign u0   = uid_reg[0];
    assign u1   = uid_reg[1];
    assign u2   = uid_reg[2];
    assign chk1 = nfca_pkg::bcc_ok(u0);
    assign chk2 = (u0[7:0] == nfca_pkg::CT_BYTE) && chk1 && nfca_pkg::bcc_ok(u1);
    assign chk3 = chk2 && (u1[7:0] == nfca_pkg::CT_BYTE) && nfca_pkg::bcc_ok(u2);

    // frame field helpers
    function automatic nfca_pkg::res_t anticoll_res(input logic [1:0] lvl,
                                                     input logic [5:0] k,
                                                     input logic [LB-1:0] bits);
        nfca_pkg::res_t r;
        r           = '0;
        r.sel_code  = nfca_pkg::SEL_BASE + {5'b0, lvl, 1'b0};
        r.nvb       = {4'd2 + {1'b0, k[5:3]}, 1'b0, k[2:0]};
        r.frame_uid = bits & ~({LB{1'b1}} << k);
        r.tx_bits   = nfca_pkg::TX_HDR_BITS + k;
        return r;
    endfunction

    // one pass per beat
    always_comb begin
        phase_next    = phase_reg;
        level_next    = level_reg;
        known_next    = known_reg;
        uid_next      = uid_reg;
        out_kind_next = out_kind_reg;
        out_res_next  = out_res_reg;
        if (fire) begin
            out_res_next  = '0;
            out_kind_next = nfca_pkg::KIND_ERROR;
            case (in_cmd_reg)
                nfca_pkg::CMD_START: begin
                    for (int i = 0; i < nfca_pkg::NUM_LEVELS; i++) begin
                        uid_next[i] = '0;
                    end
                    level_next    = 2'd1;
                    known_next    = '0;
                    phase_next    = PH_ANTICOLL;
                    out_kind_next = nfca_pkg::KIND_ANTICOLL;
                    out_res_next  = anticoll_res(2'd1, 6'd0, '0);
                end
                nfca_pkg::CMD_ANTICOLL: begin
                    if (phase_reg != PH_ANTICOLL) begin
                        out_res_next.error_code = nfca_pkg::ERR_SEQUENCE;
                        phase_next = PH_IDLE;
                    end else if (in_fail_reg) begin
                        out_res_next.error_code = nfca_pkg::ERR_RX_FAIL;
                        phase_next = PH_IDLE;
                    end else if (in_bits_reg == '0) begin
                        out_res_next.error_code = nfca_pkg::ERR_NO_PROG;
                        phase_next = PH_IDLE;
                    end else begin
                        uid_next[lvl_idx] = merged;
                        known_next        = new_known;
                        if (new_known < 6'(LB)) begin
                            out_kind_next = nfca_pkg::KIND_ANTICOLL;
                            out_res_next  = anticoll_res(level_reg, new_known, merged);
                        end else begin
                            phase_next             = PH_SELWAIT;
                            out_kind_next          = nfca_pkg::KIND_SELECT;
                            out_res_next.sel_code  = nfca_pkg::SEL_BASE
                                                     + {5'b0, level_reg, 1'b0};
                            out_res_next.nvb       = nfca_pkg::NVB_SELECT;
                            out_res_next.frame_uid = merged;
                            out_res_next.tx_bits   = nfca_pkg::TX_SELECT;
                        end
                    end
                end
                nfca_pkg::CMD_SAK: begin
                    phase_next = PH_IDLE;
                    if (phase_reg != PH_SELWAIT) begin
                        out_res_next.error_code = nfca_pkg::ERR_SEQUENCE;
                    end else if (in_fail_reg) begin
                        out_res_next.error_code = nfca_pkg::ERR_RX_FAIL;
                    end else if ((in_sak_reg & nfca_pkg::CASCADE_BIT) != '0) begin
                        if (level_reg >= 2'(nfca_pkg::MAX_LEVELS)) begin
                            out_res_next.error_code = nfca_pkg::ERR_LEVELS;
                        end else begin
                            level_next    = level_reg + 2'd1;
                            known_next    = '0;
                            phase_next    = PH_ANTICOLL;
                            out_kind_next = nfca_pkg::KIND_ANTICOLL;
                            out_res_next  = anticoll_res(level_reg + 2'd1, 6'd0, '0);
                        end
                    end else if (level_reg <= 2'd1) begin
                        if (!chk1) begin
                            out_res_next.error_code = nfca_pkg::ERR_CHECK;
                        end else begin
                            out_kind_next         = nfca_pkg::KIND_DONE;
                            out_res_next.uid_low  = {32'b0, u0[31:0]};
                            out_res_next.uid_len  = 4'd4;
                            out_res_next.sak_out  = in_sak_reg;
                        end
                    end else if (level_reg == 2'd2) begin
                        if (!chk2) begin
                            out_res_next.error_code = nfca_pkg::ERR_CHECK;
                        end else begin
                            out_kind_next         = nfca_pkg::KIND_DONE;
                            out_res_next.uid_low  = {8'b0, u1[31:0], u0[31:8]};
                            out_res_next.uid_len  = 4'd7;
                            out_res_next.sak_out  = in_sak_reg;
                        end
                    end else begin
                        if (!chk3) begin
                            out_res_next.error_code = nfca_pkg::ERR_CHECK;
                        end else begin
                            out_kind_next         = nfca_pkg::KIND_DONE;
                            out_res_next.uid_low  = {u2[15:0], u1[31:8], u0[31:8]};
                            out_res_next.uid_high = u2[31:16];
                            out_res_next.uid_len  = 4'd10;
                            out_res_next.sak_out  = in_sak_reg;
                        end
                    end
                end
                default: begin
                    out_res_next.error_code = nfca_pkg::ERR_SEQUENCE;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            level_reg   <= 2'd1;
            known_reg   <= '0;
            for (int i = 0; i < nfca_pkg::NUM_LEVELS; i++) begin
                uid_reg[i] <= '0;
            end
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            known_reg   <= known_next;
            uid_reg     <= uid_next;
        end
        in_cmd_reg   <= in_cmd_next;
        in_bits_reg  <= in_bits_next;
        in_data_reg  <= in_data_next;
        in_fail_reg  <= in_fail_next;
        in_sak_reg   <= in_sak_next;
        out_kind_reg <= out_kind_next;
        out_res_reg  <= out_res_next;
    end

    // checks
    `NFCA_ASSERT_SAME(a_level_range, aclk, aresetn, 1'b1,
        level_reg != 2'd0 && level_reg <= 2'(nfca_pkg::MAX_LEVELS), "level out of range")
    `NFCA_ASSERT_SAME(a_selwait_full, aclk, aresetn, phase_reg == PH_SELWAIT,
        known_reg == 6'(LB), "select wait without all level bits known")
    `NFCA_ASSERT_SAME(a_error_coded, aclk, aresetn, m_tvalid,
        (m_tuser == nfca_pkg::KIND_ERROR) == (m_tdata[156:154] != 3'd0),
        "error kind and error code disagree")
    `NFCA_ASSERT_NEXT(a_result_follows, aclk, aresetn, fire,
        m_tvalid && (phase_reg == PH_IDLE || m_tuser == nfca_pkg::KIND_ANTICOLL
                     || m_tuser == nfca_pkg::KIND_SELECT),
        "result missing or phase not idle after done/error")

endmodule
